FILE: rtl/gcsa_pkg.sv
// gcsa_pkg: shared types, constants and the hash mix for the glyph cache shelf allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gcsa_pkg;

	localparam int HashBucketsDef = 256;
	localparam int RowSlotsDef    = 128;
	localparam int FontSlotsDef   = 4;
	localparam int EntrySlotsDef  = 512;

	localparam logic [12:0] AtlasDimReset = 13'd512;

	localparam logic [1:0] ST_HIT    = 2'd0;
	localparam logic [1:0] ST_PLACED = 2'd1;
	localparam logic [1:0] ST_ATLAS  = 2'd2;
	localparam logic [1:0] ST_STORE  = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // latch request, start hash
		logic head_rd;     // read bucket head
		logic ent_rd;      // read entry at current pointer
		logic ent_next;    // follow link
		logic row_init;    // start shelf scan
		logic row_rd;      // read shelf at scan index
		logic row_chk;     // evaluate shelf read data
		logic last_rd;     // read last shelf
		logic decide;      // compute placement outcome
		logic commit;      // write new entry, shelf, head
		logic out_hit;     // emit hit result
		logic out_dec;     // emit placement result
	} gcsa_cmd_t;

	typedef struct packed {
		logic have;        // chain pointer valid
		logic key_match;   // entry key matches
		logic scan_done;   // all shelves visited
		logic place_ok;    // decision will commit
		logic clr_busy;    // bucket head clearing pass after reset
	} gcsa_sts_t;

	function automatic logic [31:0] mix32(input logic [31:0] a_in);
		logic [31:0] a;
		a = a_in;
		a = a + ~(a << 15);
		a = a ^ (a >> 10);
		a = a + (a << 3);
		a = a ^ (a >> 6);
		a = a + ~(a << 11);
		a = a ^ (a >> 16);
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/gcsa_ctrl.sv
// gcsa_ctrl: sequencer for chain walk, shelf scan and commit
// depends on gcsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcsa_ctrl import gcsa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire gcsa_sts_t sts,
	output logic           busy,
	output gcsa_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_HEAD, S_HWAIT, S_ECHK, S_EWAIT,
		S_RINIT, S_RRD, S_RCHK, S_LAST, S_DEC, S_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = start && !sts.clr_busy;
			S_HASH:  cmd.head_rd = 1'b1;
			S_HEAD:  cmd = '0;
			S_HWAIT: cmd.ent_rd = sts.have;
			S_ECHK: begin
				if (sts.key_match) cmd.out_hit = 1'b1;
				else cmd.ent_next = 1'b1;
			end
			S_EWAIT: cmd.ent_rd = sts.have;
			S_RINIT: cmd.row_init = 1'b1;
			S_RRD:   cmd.row_rd = !sts.scan_done;
			S_RCHK:  cmd.row_chk = 1'b1;
			S_LAST:  cmd.last_rd = 1'b1;
			S_DEC:   cmd.decide = 1'b1;
			S_DONE: begin
				cmd.out_dec = 1'b1;
				cmd.commit  = sts.place_ok;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE) || sts.clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (start && !sts.clr_busy) state_q <= S_HASH;
				S_HASH:  state_q <= S_HEAD;
				S_HEAD:  state_q <= S_HWAIT;
				S_HWAIT: state_q <= sts.have ? S_ECHK : S_RINIT;
				S_ECHK:  state_q <= sts.key_match ? S_IDLE : S_EWAIT;
				S_EWAIT: state_q <= sts.have ? S_ECHK : S_RINIT;
				S_RINIT: state_q <= S_RRD;
				S_RRD:   state_q <= sts.scan_done ? S_LAST : S_RCHK;
				S_RCHK:  state_q <= S_RRD;
				S_LAST:  state_q <= S_DEC;
				S_DEC:   state_q <= S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/gcsa_dp.sv
// gcsa_dp: hash, bucket heads, entry store, shelf table and placement arithmetic
// depends on gcsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcsa_dp import gcsa_pkg::*; #(
	parameter int HASH_BUCKETS = HashBucketsDef,
	parameter int ROW_SLOTS    = RowSlotsDef,
	parameter int FONT_SLOTS   = FontSlotsDef,
	parameter int ENTRY_SLOTS  = EntrySlotsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire gcsa_cmd_t   cmd,
	output gcsa_sts_t        sts,
	input  wire logic [12:0] atlas_width,
	input  wire logic [12:0] atlas_height,
	input  wire logic [1:0]  font_index,
	input  wire logic [20:0] code_point,
	input  wire logic [14:0] size_key,
	input  wire logic [11:0] glyph_width,
	input  wire logic [11:0] glyph_height,
	output logic             done,
	output logic [1:0]       status,
	output logic [11:0]      box_x,
	output logic [11:0]      box_y,
	output logic [11:0]      box_width,
	output logic [11:0]      box_height
);

	localparam int HB = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
	localparam int FB = (FONT_SLOTS > 1) ? $clog2(FONT_SLOTS) : 1;
	localparam int NH = FONT_SLOTS * HASH_BUCKETS;
	localparam int HA = $clog2(NH);
	localparam int HC = HA + 1;
	localparam int EB = $clog2(ENTRY_SLOTS);
	localparam int RB = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
	localparam int RC = $clog2(ROW_SLOTS + 1);
	localparam int EC = $clog2(ENTRY_SLOTS + 1);
	localparam int KW = 38;

	// request registers
	logic [1:0]  font_q;
	logic [20:0] cp_q;
	logic [14:0] sz_q;
	logic [11:0] gw_q, gh_q;
	logic [HA-1:0] bkt_q;
	logic [12:0] rh_q;

	// memories
	logic [EB:0]   head_mem [NH];            // msb is head valid
	logic [KW-1:0] key_mem  [ENTRY_SLOTS];
	logic [47:0]   box_mem  [ENTRY_SLOTS];
	logic [EB:0]   link_mem [ENTRY_SLOTS];   // msb is link valid
	logic [12:0]   rfill_mem [ROW_SLOTS];
	logic [25:0]   rgeom_mem [ROW_SLOTS];    // top, height

	logic [HC-1:0] clr_q;
	logic          clr_busy;
	logic [EB-1:0] ptr_q;
	logic          have_q, have0_q;
	logic          chain_started_q;
	logic [EB-1:0] head0_q;
	logic [KW-1:0] key_rd_q;
	logic [47:0]   box_rd_q;
	logic [EB:0]   link_rd_q;
	logic [EC-1:0] ecnt_q;
	logic [RC-1:0] rcnt_q;
	logic [RC-1:0] ridx_q;
	logic [12:0]   rfill_rd_q;
	logic [25:0]   rgeom_rd_q;
	logic          found_q;
	logic [RB-1:0] frow_q;
	logic [12:0]   fx_q, fy_q;
	logic [12:0]   px_q, py_q;
	logic          ok_q;
	logic [1:0]    fail_q;

	logic [FB-1:0] font_m;
	logic [KW-1:0] key_w;
	logic [31:0]   mixed;
	logic [13:0]   need_x;
	logic [13:0]   new_y;
	logic [14:0]   new_bot;

	// font index is at most 3, so one subtract folds it into range
	always_comb begin
		if (FONT_SLOTS == 1) font_m = '0;
		else if (32'(font_index) >= FONT_SLOTS) font_m = FB'(32'(font_index) - FONT_SLOTS);
		else font_m = FB'(font_index);
	end
	assign mixed = mix32({11'd0, code_point});
	assign key_w = {font_q, cp_q, sz_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			font_q <= 2'(font_m);
			cp_q   <= code_point;
			sz_q   <= size_key;
			gw_q   <= glyph_width;
			gh_q   <= glyph_height;
			bkt_q  <= HA'(font_m * HASH_BUCKETS) | HA'(mixed[HB-1:0]);
			rh_q   <= ({1'b0, glyph_height} + 13'd7) & ~13'd7;
		end
	end

	// clearing pass over the bucket heads after reset, one head per cycle
	assign clr_busy = (clr_q != HC'(NH));
	assign sts.clr_busy = clr_busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// bucket heads: valid bit and pointer in one memory word
	always_ff @(posedge clk) begin
		if (cmd.head_rd) {have0_q, head0_q} <= head_mem[bkt_q];
		if (clr_busy) head_mem[clr_q[HA-1:0]] <= '0;
		else if (cmd.commit) head_mem[bkt_q] <= {1'b1, ptr_q};
	end

	// entry store
	always_ff @(posedge clk) begin
		if (cmd.ent_rd) begin
			key_rd_q  <= key_mem[ptr_q];
			box_rd_q  <= box_mem[ptr_q];
			link_rd_q <= link_mem[ptr_q];
		end
		if (cmd.commit) begin
			key_mem[ptr_q]  <= key_w;
			box_mem[ptr_q]  <= {px_q[11:0], py_q[11:0], gw_q, gh_q};
			link_mem[ptr_q] <= {have0_q, head0_q};
		end
	end

	// pointer and chain valid: head on first look, link afterwards, new slot at decide
	always_ff @(posedge clk) begin
		if (cmd.load) have_q <= 1'b0;
		else if (cmd.head_rd) have_q <= 1'b0;
		else if (cmd.ent_next) have_q <= link_rd_q[EB];
		if (cmd.ent_next) ptr_q <= link_rd_q[EB-1:0];
		else if (cmd.decide) ptr_q <= ecnt_q[EB-1:0];
		else if (!have_q) ptr_q <= head0_q;
	end
	// first chain look uses the bucket head valid
	assign sts.have = have_q | (have0_q & ~chain_started_q);
	always_ff @(posedge clk) begin
		if (cmd.head_rd) chain_started_q <= 1'b0;
		else if (cmd.ent_rd) chain_started_q <= 1'b1;
	end
	assign sts.key_match = (key_rd_q == key_w);

	// shelf table
	always_ff @(posedge clk) begin
		if (cmd.row_rd) begin
			rfill_rd_q <= rfill_mem[ridx_q[RB-1:0]];
			rgeom_rd_q <= rgeom_mem[ridx_q[RB-1:0]];
		end else if (cmd.last_rd && rcnt_q != '0) begin
			rgeom_rd_q <= rgeom_mem[RB'(rcnt_q - 1'b1)];
		end
		if (cmd.commit) begin
			if (found_q) begin
				rfill_mem[frow_q] <= fx_q + 13'(gw_q) + 13'd1;
			end else begin
				rfill_mem[rcnt_q[RB-1:0]] <= 13'(gw_q) + 13'd1;
				rgeom_mem[rcnt_q[RB-1:0]] <= {py_q, rh_q};
			end
		end
	end

	assign need_x = 14'(rfill_rd_q) + 14'(gw_q) + 14'd1;
	assign sts.scan_done = (ridx_q >= rcnt_q);

	always_ff @(posedge clk) begin
		if (cmd.row_init) begin
			ridx_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.row_rd) begin
			ridx_q <= ridx_q + 1'b1;
		end else if (cmd.row_chk) begin
			if (rgeom_rd_q[12:0] == rh_q && need_x <= 14'(atlas_width)) begin
				found_q <= 1'b1;
				frow_q  <= RB'(ridx_q - 1'b1);
				fx_q    <= rfill_rd_q;
				fy_q    <= rgeom_rd_q[25:13];
			end
		end
	end

	assign new_y   = 14'(rgeom_rd_q[25:13]) + 14'(rgeom_rd_q[12:0]) + 14'd1;
	assign new_bot = 15'(new_y) + 15'(rh_q);

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			ok_q   <= 1'b0;
			fail_q <= ST_PLACED;
			if (found_q) begin
				px_q <= fx_q;
				py_q <= fy_q;
			end else begin
				px_q <= '0;
				py_q <= (rcnt_q == '0) ? 13'd0 : new_y[12:0];
			end
			if (!found_q && rcnt_q >= RC'(ROW_SLOTS)) fail_q <= ST_ATLAS;
			else if (!found_q && rcnt_q != '0 && new_bot > 15'(atlas_height))
				fail_q <= ST_ATLAS;
			else if (ecnt_q >= EC'(ENTRY_SLOTS)) fail_q <= ST_STORE;
			else ok_q <= 1'b1;
		end
	end
	assign sts.place_ok = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecnt_q <= '0;
			rcnt_q <= '0;
		end else if (cmd.commit) begin
			ecnt_q <= ecnt_q + 1'b1;
			if (!found_q) rcnt_q <= rcnt_q + 1'b1;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.out_hit | cmd.out_dec;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_hit) begin
			status     <= ST_HIT;
			box_x      <= box_rd_q[47:36];
			box_y      <= box_rd_q[35:24];
			box_width  <= box_rd_q[23:12];
			box_height <= box_rd_q[11:0];
		end else if (cmd.out_dec) begin
			status     <= ok_q ? ST_PLACED : fail_q;
			box_x      <= ok_q ? px_q[11:0] : 12'd0;
			box_y      <= ok_q ? py_q[11:0] : 12'd0;
			box_width  <= ok_q ? gw_q : 12'd0;
			box_height <= ok_q ? gh_q : 12'd0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/glyph_cache_shelf_allocator.sv
// glyph_cache_shelf_allocator: top level, config registers, controller and datapath
// depends on gcsa_pkg, gcsa_ctrl, gcsa_dp
//
// channel   direction  handshake                 payload
// request   in         start & !busy             font_index code_point size_key glyph_*
// result    out        done (one cycle strobe)   status box_x box_y box_width box_height
// config    in         cfg_we                    cfg_index cfg_data
//
// one request at a time, with these steps while busy:
// hit: hash and head read, then a read and a compare per chain entry
// miss: the chain walk, then the scan over the open shelves, last shelf, decide, commit
// the chain walk and the serial shelf scan over the shelf memory set the latency
// reset clears entry and shelf counts, then a clearing pass empties all FONT_SLOTS*HASH_BUCKETS
// bucket heads (1024 by default) while busy stays high
// the result strobe cannot be stalled; busy drops in the cycle the strobe is shown
`timescale 1ns / 1ps
`default_nettype none
module glyph_cache_shelf_allocator import gcsa_pkg::*; #(
	parameter int HASH_BUCKETS = HashBucketsDef,
	parameter int ROW_SLOTS    = RowSlotsDef,
	parameter int FONT_SLOTS   = FontSlotsDef,
	parameter int ENTRY_SLOTS  = EntrySlotsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  font_index,
	input  wire logic [20:0] code_point,
	input  wire logic [14:0] size_key,
	input  wire logic [11:0] glyph_width,
	input  wire logic [11:0] glyph_height,
	output logic             done,
	output logic [1:0]       status,
	output logic [11:0]      box_x,
	output logic [11:0]      box_y,
	output logic [11:0]      box_width,
	output logic [11:0]      box_height,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);

	logic [12:0] atlas_width_q, atlas_height_q;
	gcsa_cmd_t   cmd;
	gcsa_sts_t   sts;

	// configuration word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= AtlasDimReset;
			atlas_height_q <= AtlasDimReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  atlas_width_q  <= cfg_data;
				REG_HEIGHT: atlas_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gcsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	gcsa_dp #(
		.HASH_BUCKETS (HASH_BUCKETS),
		.ROW_SLOTS    (ROW_SLOTS),
		.FONT_SLOTS   (FONT_SLOTS),
		.ENTRY_SLOTS  (ENTRY_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.atlas_width  (atlas_width_q),
		.atlas_height (atlas_height_q),
		.font_index   (font_index),
		.code_point   (code_point),
		.size_key     (size_key),
		.glyph_width  (glyph_width),
		.glyph_height (glyph_height),
		.done         (done),
		.status       (status),
		.box_x        (box_x),
		.box_y        (box_y),
		.box_width    (box_width),
		.box_height   (box_height)
	);

	// a result word only follows an accepted request
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without request in flight");

	// commit and hit never in the same cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.out_hit))
		else $error("commit during hit");

	// result strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire
